### hw/rtl/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

  localparam int ROWS          = 25;
  localparam int COLS          = 80;
  localparam int CELLS         = ROWS * COLS;
  localparam int ROW_W         = $clog2(ROWS);
  localparam int COL_W         = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int ADDR_W        = $clog2(CELLS);
  localparam int LAST_ROW_BASE = (ROWS - 1) * COLS;
  localparam int FIFO_DEPTH    = 2;

  localparam logic [1:0] FUNC_PRINT     = 2'd0;
  localparam logic [1:0] FUNC_BACKSPACE = 2'd1;
  localparam logic [1:0] FUNC_READ      = 2'd2;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  typedef enum logic [2:0] {
    CMD_PRINT,
    CMD_NEWLINE,
    CMD_BACKSPACE,
    CMD_READ,
    CMD_NOP
  } cmd_op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCROLL
  } back_state_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] char_code;
    logic [7:0] attr;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } tcw_in_t;

  typedef struct packed {
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
  } tcw_out_t;

  typedef struct packed {
    cmd_op_e           op;
    logic [15:0]       glyph;
    logic [ADDR_W-1:0] addr;
  } tcw_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/tcw_front.sv
`default_nettype none

module tcw_front (
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tcw_pkg::tcw_in_t in_data_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output tcw_pkg::tcw_cmd_t cmd_o
);
  import tcw_pkg::*;

  logic in_range;

  assign in_range = (32'(in_data_i.read_row) < ROWS) && (32'(in_data_i.read_col) < COLS);

  assign cmd_valid_o = in_valid_i;
  assign in_ready_o  = cmd_ready_i;

  always_comb begin
    cmd_o.glyph = {in_data_i.attr, in_data_i.char_code};
    // linear cell address, only meaningful for an in-range read
    cmd_o.addr = ADDR_W'(32'(in_data_i.read_row) * COLS + 32'(in_data_i.read_col));
    case (in_data_i.func)
      FUNC_PRINT: begin
        cmd_o.op = (in_data_i.char_code == NEWLINE_CODE) ? CMD_NEWLINE : CMD_PRINT;
      end
      FUNC_BACKSPACE: begin
        cmd_o.op = CMD_BACKSPACE;
      end
      FUNC_READ: begin
        // off-screen read answers like an unused code
        cmd_o.op = in_range ? CMD_READ : CMD_NOP;
      end
      default: begin
        cmd_o.op = CMD_NOP;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/tcw_fifo.sv
`default_nettype none

module tcw_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  tcw_pkg::tcw_cmd_t  push_data_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output tcw_pkg::tcw_cmd_t  pop_data_o
);
  import tcw_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  tcw_cmd_t         entries_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = count_q != CNT_W'(FIFO_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/tcw_back.sv
`default_nettype none

module tcw_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  tcw_pkg::tcw_cmd_t cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tcw_pkg::tcw_out_t out_data_o
);
  import tcw_pkg::*;

  logic [15:0]       screen_q [CELLS];
  logic [15:0]       rdata_q;

  back_state_e       state_q, state_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic              wr_valid_q, wr_valid_d;
  logic              wr_zero_q, wr_zero_d;
  logic [ADDR_W-1:0] wr_addr_q, wr_addr_d;
  logic              out_valid_q, out_valid_d;
  tcw_out_t          out_q, out_d;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [15:0]       mem_wdata;
  logic              out_free, take, load_out;
  logic              at_last_cell, at_last_row, at_last_col, cnt_last;

  assign out_free     = !out_valid_q || out_ready_i;
  // a pending scroll write owns the write port, so hold the queue for it
  assign cmd_ready_o  = (state_q == ST_IDLE) && !wr_valid_q && out_free;
  assign take         = cmd_ready_o && cmd_valid_i;
  assign at_last_cell = pos_q == ADDR_W'(CELLS - 1);
  assign at_last_row  = row_q == ROW_W'(ROWS - 1);
  assign at_last_col  = col_q == COL_W'(COLS - 1);
  assign cnt_last     = cnt_q == ADDR_W'(CELLS - 1);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (cnt_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (take) begin
          case (cmd_i.op)
            CMD_PRINT:   if (at_last_cell) state_d = ST_SCROLL;
            CMD_NEWLINE: if (at_last_row) state_d = ST_SCROLL;
            CMD_READ:    state_d = ST_READ;
            default:     state_d = state_q;
          endcase
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
      end
      ST_SCROLL: begin
        if (cnt_last) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    pos_d       = pos_q;
    row_d       = row_q;
    col_d       = col_q;
    cnt_d       = cnt_q;
    wr_valid_d  = 1'b0;
    wr_zero_d   = wr_zero_q;
    wr_addr_d   = wr_addr_q;
    mem_we      = wr_valid_q;
    mem_waddr   = wr_addr_q;
    mem_wdata   = wr_zero_q ? '0 : rdata_q;
    mem_re      = 1'b0;
    mem_raddr   = cmd_i.addr;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    load_out    = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = '0;
        cnt_d     = cnt_q + 1'b1;
      end
      ST_IDLE: begin
        if (take) begin
          load_out = 1'b1;
          case (cmd_i.op)
            CMD_PRINT: begin
              mem_we    = 1'b1;
              mem_waddr = pos_q;
              mem_wdata = cmd_i.glyph;
              if (at_last_cell) begin
                pos_d = ADDR_W'(LAST_ROW_BASE);
                row_d = ROW_W'(ROWS - 1);
                col_d = '0;
                cnt_d = ADDR_W'(COLS);
              end else begin
                pos_d = pos_q + 1'b1;
                if (at_last_col) begin
                  col_d = '0;
                  row_d = row_q + 1'b1;
                end else begin
                  col_d = col_q + 1'b1;
                end
              end
            end
            CMD_NEWLINE: begin
              col_d = '0;
              if (at_last_row) begin
                pos_d = ADDR_W'(LAST_ROW_BASE);
                cnt_d = ADDR_W'(COLS);
              end else begin
                row_d = row_q + 1'b1;
                pos_d = pos_q - ADDR_W'(col_q) + ADDR_W'(COLS);
              end
            end
            CMD_BACKSPACE: begin
              if (pos_q != '0) begin
                pos_d     = pos_q - 1'b1;
                mem_we    = 1'b1;
                mem_waddr = pos_q - 1'b1;
                mem_wdata = '0;
                if (col_q == '0) begin
                  col_d = COL_W'(COLS - 1);
                  row_d = row_q - 1'b1;
                end else begin
                  col_d = col_q - 1'b1;
                end
              end
            end
            CMD_READ: begin
              load_out  = 1'b0;
              mem_re    = 1'b1;
              mem_raddr = cmd_i.addr;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        out_valid_d          = 1'b1;
        out_d.cursor_row     = 5'(row_q);
        out_d.cursor_col     = 7'(col_q);
        out_d.cell_char      = rdata_q[7:0];
        out_d.cell_attr      = rdata_q[15:8];
      end
      ST_SCROLL: begin
        // read one row below, write it back in the next cycle; last row gets zeros
        wr_valid_d = 1'b1;
        wr_addr_d  = cnt_q;
        cnt_d      = cnt_q + 1'b1;
        if (32'(cnt_q) < LAST_ROW_BASE) begin
          wr_zero_d = 1'b0;
          mem_re    = 1'b1;
          mem_raddr = cnt_q + ADDR_W'(COLS);
        end else begin
          wr_zero_d = 1'b1;
        end
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase

    if (load_out) begin
      out_valid_d      = 1'b1;
      out_d.cursor_row = 5'(row_d);
      out_d.cursor_col = 7'(col_d);
      out_d.cell_char  = '0;
      out_d.cell_attr  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      pos_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      cnt_q       <= '0;
      wr_valid_q  <= 1'b0;
      wr_zero_q   <= 1'b0;
      wr_addr_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      row_q       <= row_d;
      col_q       <= col_d;
      cnt_q       <= cnt_d;
      wr_valid_q  <= wr_valid_d;
      wr_zero_q   <= wr_zero_d;
      wr_addr_q   <= wr_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      screen_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= screen_q[mem_raddr];
    end
  end

`ifndef SYNTHESIS
  a_cursor_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) == 32'(row_q) * COLS + 32'(col_q))
    else $error("cursor position disagrees with row and column");

  a_cursor_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) < CELLS)
    else $error("cursor beyond last cell");

  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCROLL |-> (at_last_row && col_q == '0))
    else $error("cursor not at start of last row during scroll");

  a_read_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> !out_valid_q || out_ready_i)
    else $error("read result would overwrite an untaken word");

  a_no_pop_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR || state_q == ST_SCROLL) |-> !take)
    else $error("command taken during clear or scroll");
`endif

endmodule

`default_nettype wire

### hw/rtl/text_console_writer.sv
`default_nettype none

// text-mode screen of ROWS x COLS cells (character in the low byte, colour attribute in the
// high byte) with a write cursor. each input word is a print (char 10 is a newline),
// a backspace or a cell read, and gives exactly one output word carrying the cursor row and
// column after it, plus the cell contents for a read. words enter a two-entry queue and are
// carried out one at a time against a single-port-write, single-port-read screen memory:
// print, newline, backspace and unused codes are done when taken; a read also passes a read
// state that loads its result. when the cursor runs off the last cell or a newline is
// given on the last row the screen scrolls, copying the rows below the second up one row
// (the top row stays) and clearing the bottom row one cell per cycle. after reset a clearing
// pass zeroes all ROWS*COLS cells before any word is carried out; words may queue meanwhile.
module text_console_writer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tcw_pkg::tcw_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tcw_pkg::tcw_out_t out_data_o
);
  import tcw_pkg::*;

  logic     push_valid, push_ready;
  tcw_cmd_t push_cmd;
  logic     pop_valid, pop_ready;
  tcw_cmd_t pop_cmd;

  tcw_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (push_valid),
    .cmd_ready_i (push_ready),
    .cmd_o       (push_cmd)
  );

  tcw_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_cmd)
  );

  tcw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
